// ===== hdl/asts_pkg.sv =====
// Shared types, codes and constants of the ADC scan and telemetry sequencer.
`default_nettype none

package asts_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int PKT_LEN         = 8;
  localparam int PKT_IDX_W       = $clog2(PKT_LEN);

  // Run states and channel selection
  localparam logic [1:0] RUN_IDLE   = 2'd0;
  localparam logic [1:0] RUN_STREAM = 2'd2;
  localparam logic [1:0] CHAN_FIRST = 2'd1;

  // Reset values of the configuration registers
  localparam logic [1:0]  RUN_STATE_RST      = RUN_IDLE;
  localparam logic [1:0]  CHANNEL_MODE_RST   = CHAN_FIRST;
  localparam logic [15:0] STREAM_PERIOD_RST  = 16'd20;
  localparam logic [15:0] MONITOR_PERIOD_RST = 16'd20000;

  // Converter register addresses and values
  localparam logic [3:0] REG_ADDR_OSR = 4'h2;
  localparam logic [3:0] REG_ADDR_MUX = 4'h6;
  localparam logic [7:0] OSR_SLOW     = 8'h0E;
  localparam logic [7:0] OSR_FAST     = 8'h0C;
  localparam logic [7:0] MUX_CUR_A    = 8'h2C;
  localparam logic [7:0] MUX_CUR_B    = 8'h3C;
  localparam logic [7:0] MUX_VOLT_A   = 8'h01;
  localparam logic [7:0] MUX_VOLT_B   = 8'h45;
  localparam logic [7:0] MUX_TEMP     = 8'h6C;

  localparam logic [2:0] WAIT_OSR = 3'd4;
  localparam logic [2:0] WAIT_STD = 3'd1;

  // Packet framing
  localparam logic [7:0] SYNC_ONE = 8'hAA;
  localparam logic [7:0] SYNC_TWO = 8'h55;
  localparam logic [7:0] MON_MODE = 8'h03;

  typedef enum logic [1:0] {
    CFG_RUN_STATE      = 2'd0,
    CFG_CHANNEL_MODE   = 2'd1,
    CFG_STREAM_PERIOD  = 2'd2,
    CFG_MONITOR_PERIOD = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_OSR,
    BK_MUX,
    BK_MEAS,
    BK_MON
  } bk_state_t;

  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [7:0] d4;
    logic [7:0] chk;
  } pkt_t;

  // Everything one tick asks the back end to send
  typedef struct packed {
    logic       has_osr;
    logic [7:0] osr_val;
    logic       has_mux;
    logic [7:0] mux_val;
    logic       has_meas;
    pkt_t       meas;
    logic       has_mon;
    pkt_t       mon;
  } job_t;

  function automatic pkt_t make_pkt(input logic [7:0] mode, input logic [7:0] d1,
                                    input logic [7:0] d2, input logic [7:0] d3,
                                    input logic [7:0] d4);
    pkt_t p;
    p.mode = mode;
    p.d1   = d1;
    p.d2   = d2;
    p.d3   = d3;
    p.d4   = d4;
    p.chk  = mode ^ d1 ^ d2 ^ d3 ^ d4;
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/asts_tick_if.sv =====
// Tick channel: converter word and fan speeds, valid/ready handshake.
`default_nettype none

interface asts_tick_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] adc_sample;
  logic [7:0]        fan_one_speed;
  logic [7:0]        fan_two_speed;

  modport source (output valid, output adc_sample, output fan_one_speed,
                  output fan_two_speed, input ready);
  modport sink   (input valid, input adc_sample, input fan_one_speed,
                  input fan_two_speed, output ready);
endinterface

`default_nettype wire

// ===== hdl/asts_res_if.sv =====
// Result channel: converter register writes and serial bytes, valid/ready handshake.
`default_nettype none

interface asts_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [3:0] conv_reg_addr;
  logic [7:0] conv_reg_value;
  logic [7:0] tx_byte;
  logic       last_of_run;

  modport source (output valid, output out_kind, output conv_reg_addr,
                  output conv_reg_value, output tx_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_kind, input conv_reg_addr,
                  input conv_reg_value, input tx_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/asts_front.sv =====
// Front end: configuration registers, scan and counter state, job building per tick.
`default_nettype none

module asts_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire asts_pkg::cfg_idx_t cfg_index,
  input  wire logic [asts_pkg::CFG_DATA_W-1:0] cfg_data,
  asts_tick_if.sink               in_ch,
  input  wire logic               q_full,
  output logic                    push,
  output asts_pkg::job_t          push_job
);
  import asts_pkg::*;

  localparam logic [2:0] SLOT_LAST_VOLT = 3'd5;
  localparam logic [2:0] SLOT_TEMP_ONE  = 3'd6;
  localparam logic [2:0] SLOT_TEMP_TWO  = 3'd7;
  localparam logic [2:0] SLOT_SCAN_END  = 3'd6;

  logic [1:0]  run_state_r, channel_mode_r;
  logic [15:0] stream_period_r, monitor_period_r;

  logic [2:0]  slot_r, slot_nxt;
  logic [2:0]  wait_r, wait_nxt;
  logic [15:0] stream_r, stream_nxt;
  logic [15:0] mon_r, mon_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [15:0] volt_r, volt_nxt;
  logic [7:0]  temp_one_r, temp_one_nxt;
  logic [7:0]  temp_two_r, temp_two_nxt;

  logic        accept, active, first;
  logic [15:0] stream_inc, mon_inc;
  job_t        job;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = accept && (run_state_r != RUN_IDLE);
  assign first       = (channel_mode_r == CHAN_FIRST);
  assign stream_inc  = stream_r + 16'd1;
  assign mon_inc     = mon_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_state_r      <= RUN_STATE_RST;
      channel_mode_r   <= CHANNEL_MODE_RST;
      stream_period_r  <= STREAM_PERIOD_RST;
      monitor_period_r <= MONITOR_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUN_STATE:      run_state_r      <= cfg_data[1:0];
        CFG_CHANNEL_MODE:   channel_mode_r   <= cfg_data[1:0];
        CFG_STREAM_PERIOD:  stream_period_r  <= cfg_data[15:0];
        CFG_MONITOR_PERIOD: monitor_period_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_nxt     = slot_r;
    wait_nxt     = wait_r;
    stream_nxt   = stream_r;
    mon_nxt      = mon_r;
    cur_nxt      = cur_r;
    volt_nxt     = volt_r;
    temp_one_nxt = temp_one_r;
    temp_two_nxt = temp_two_r;
    job          = '0;

    if (active) begin
      if (wait_r != 3'd0) begin
        wait_nxt = wait_r - 3'd1;
      end else begin
        job.has_mux = 1'b1;
        if (slot_r < SLOT_SCAN_END) begin
          if (!slot_r[0]) begin
            cur_nxt     = in_ch.adc_sample[23:8];
            job.mux_val = first ? MUX_CUR_A : MUX_CUR_B;
          end else begin
            volt_nxt    = in_ch.adc_sample[23:8];
            job.mux_val = first ? MUX_VOLT_A : MUX_VOLT_B;
          end
        end else if (slot_r == SLOT_TEMP_ONE) begin
          temp_one_nxt = in_ch.adc_sample[23:16];
          job.mux_val  = MUX_TEMP;
        end else begin
          temp_two_nxt = in_ch.adc_sample[23:16];
          job.mux_val  = first ? MUX_VOLT_A : MUX_VOLT_B;
        end

        // oversampling changes around the temperature pair
        if (slot_r == SLOT_LAST_VOLT) begin
          job.has_osr = 1'b1;
          job.osr_val = OSR_SLOW;
          wait_nxt    = WAIT_OSR;
        end else if (slot_r == SLOT_TEMP_TWO) begin
          job.has_osr = 1'b1;
          job.osr_val = OSR_FAST;
          wait_nxt    = WAIT_STD;
        end else begin
          wait_nxt    = WAIT_STD;
        end
        slot_nxt = slot_r + 3'd1;
      end

      if (run_state_r == RUN_STREAM && stream_inc >= stream_period_r) begin
        stream_nxt   = 16'd0;
        job.has_meas = 1'b1;
        job.meas     = make_pkt({6'd0, channel_mode_r}, cur_nxt[15:8], cur_nxt[7:0],
                                volt_nxt[15:8], volt_nxt[7:0]);
      end else begin
        stream_nxt   = stream_inc;
      end

      if (mon_inc >= monitor_period_r) begin
        mon_nxt     = 16'd0;
        job.has_mon = 1'b1;
        job.mon     = make_pkt(MON_MODE, temp_one_nxt, temp_two_nxt,
                               in_ch.fan_one_speed, in_ch.fan_two_speed);
      end else begin
        mon_nxt     = mon_inc;
      end
    end
  end

  assign push     = active && (job.has_mux || job.has_meas || job.has_mon);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      wait_r     <= '0;
      stream_r   <= '0;
      mon_r      <= '0;
      cur_r      <= '0;
      volt_r     <= '0;
      temp_one_r <= '0;
      temp_two_r <= '0;
    end else begin
      slot_r     <= slot_nxt;
      wait_r     <= wait_nxt;
      stream_r   <= stream_nxt;
      mon_r      <= mon_nxt;
      cur_r      <= cur_nxt;
      volt_r     <= volt_nxt;
      temp_one_r <= temp_one_nxt;
      temp_two_r <= temp_two_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/asts_queue.sv =====
// Job queue between the front end and the back end.
`default_nettype none

module asts_queue #(
  parameter int DEPTH = asts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire asts_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output asts_pkg::job_t      head_job
);
  import asts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/asts_back.sv =====
// Back end: walks one job and sends its register writes and packet bytes.
`default_nettype none

module asts_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire asts_pkg::job_t q_job,
  output logic                q_pop,
  asts_res_if.source          out_ch
);
  import asts_pkg::*;

  bk_state_t              state_r, state_nxt;
  logic [PKT_IDX_W-1:0]   idx_r, idx_nxt;
  job_t                   job_r;

  logic                   out_valid_r;
  logic                   kind_r, last_r;
  logic [3:0]             addr_r;
  logic [7:0]             value_r, byte_r;

  logic                   emit_ok, emit;
  logic                   item_kind, item_last;
  logic [3:0]             item_addr;
  logic [7:0]             item_value, item_byte;
  bk_state_t              seg_n;

  // Segment that follows cur for this job; idle when nothing is left
  function automatic bk_state_t seg_after(input job_t j, input bk_state_t cur);
    bk_state_t s;
    s = BK_IDLE;
    if (cur == BK_IDLE && j.has_osr)
      s = BK_OSR;
    else if ((cur == BK_IDLE || cur == BK_OSR) && j.has_mux)
      s = BK_MUX;
    else if ((cur == BK_IDLE || cur == BK_OSR || cur == BK_MUX) && j.has_meas)
      s = BK_MEAS;
    else if (cur != BK_MON && j.has_mon)
      s = BK_MON;
    return s;
  endfunction

  function automatic logic [7:0] pkt_byte(input pkt_t p, input logic [PKT_IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = SYNC_ONE;
      3'd1:    b = SYNC_TWO;
      3'd2:    b = p.mode;
      3'd3:    b = p.d1;
      3'd4:    b = p.d2;
      3'd5:    b = p.d3;
      3'd6:    b = p.d4;
      default: b = p.chk;
    endcase
    return b;
  endfunction

  assign emit_ok = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    item_kind  = 1'b0;
    item_addr  = 4'd0;
    item_value = 8'd0;
    item_byte  = 8'd0;
    item_last  = 1'b0;
    seg_n      = seg_after(job_r, state_r);

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = seg_after(q_job, BK_IDLE);
          idx_nxt   = '0;
        end
      end
      BK_OSR, BK_MUX: begin
        item_addr  = (state_r == BK_OSR) ? REG_ADDR_OSR : REG_ADDR_MUX;
        item_value = (state_r == BK_OSR) ? job_r.osr_val : job_r.mux_val;
        if (emit_ok) begin
          emit      = 1'b1;
          state_nxt = seg_n;
          item_last = (seg_n == BK_IDLE);
        end
      end
      BK_MEAS, BK_MON: begin
        item_kind = 1'b1;
        item_byte = pkt_byte((state_r == BK_MEAS) ? job_r.meas : job_r.mon, idx_r);
        if (emit_ok) begin
          emit = 1'b1;
          if (idx_r != PKT_IDX_W'(PKT_LEN - 1)) begin
            idx_nxt = idx_r + PKT_IDX_W'(1);
          end else begin
            idx_nxt   = '0;
            state_nxt = seg_n;
            item_last = (seg_n == BK_IDLE);
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= item_kind;
      addr_r  <= item_addr;
      value_r <= item_value;
      byte_r  <= item_byte;
      last_r  <= item_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = kind_r;
  assign out_ch.conv_reg_addr  = addr_r;
  assign out_ch.conv_reg_value = value_r;
  assign out_ch.tx_byte        = byte_r;
  assign out_ch.last_of_run    = last_r;

  a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE && q_valid) |=> (state_r != BK_IDLE))
    else $error("back end loaded a job with nothing to send");

endmodule

`default_nettype wire

// ===== hdl/adc_scan_telemetry_sequencer.sv =====
// Top level: ADC scan and telemetry sequencer.
//
// in_ch takes one tick per transfer (converter word and two fan bytes).
// out_ch gives converter register writes (out_kind 0) and serial packet bytes
// (out_kind 1); last_of_run marks the final result of a tick. cfg_we writes
// run_state, channel_mode, stream_period and monitor_period by index.
// The front end handles a tick in the cycle it is accepted and queues a job;
// ticks are taken every cycle while the job queue (QUEUE_DEPTH entries) has room.
// The back end sends one result per cycle from its output register while out_ch
// is ready; a tick's job passes through the queue and the back end's pop before its
// first result is registered, and each job holds the back end for its results plus
// the queue pop. Ticks that cause nothing queue no job.
// When out_ch stalls the output register holds, the back end stops, and ticks
// keep coming in until the queue fills.
// Reset (rst_n low, synchronous) clears the scan, counters, stored readings,
// queue and output, and loads the register defaults (idle, first pair, 20, 20000).
`default_nettype none

module adc_scan_telemetry_sequencer #(
  parameter int QUEUE_DEPTH = asts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire asts_pkg::cfg_idx_t cfg_index,
  input  wire logic [asts_pkg::CFG_DATA_W-1:0] cfg_data,
  asts_tick_if.sink               in_ch,
  asts_res_if.source              out_ch
);
  import asts_pkg::*;

  logic q_push, q_pop, q_full, q_not_empty;
  job_t push_job, head_job;

  asts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_job  (push_job)
  );

  asts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  asts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/asts_scan_checker.sv =====
// Checker for the ADC scan sequencer: watches all ports, predicts results and compares them.
`timescale 1ns / 1ps

module asts_scan_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  asts_pkg::cfg_idx_t              cfg_index,
  input  logic [asts_pkg::CFG_DATA_W-1:0] cfg_data,
  asts_tick_if                            tick_bus,
  asts_res_if                             res_bus,
  output int                              mismatch_count,
  output int                              pending_count
);
  import asts_pkg::*;

  localparam logic KIND_REG_WRITE = 1'b0;
  localparam logic KIND_SERIAL    = 1'b1;
  localparam int   REPORT_LIMIT   = 10;

  typedef struct packed {
    logic       kind;
    logic [3:0] addr;
    logic [7:0] value;
    logic [7:0] tx;
    logic       last;
  } scan_result_t;

  // Register copies
  logic [1:0]  run_mode;
  logic [1:0]  chan_sel;
  logic [15:0] meas_period;
  logic [15:0] mon_period;

  // Scan and telemetry state
  logic [2:0]  slot;
  logic [2:0]  settle_wait;
  logic [15:0] meas_ticks;
  logic [15:0] mon_ticks;
  logic [15:0] cur_reading;
  logic [15:0] volt_reading;
  logic [7:0]  temp_a;
  logic [7:0]  temp_b;

  scan_result_t due_results[$];
  scan_result_t tick_burst[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic void add_write(input logic [3:0] addr, input logic [7:0] value);
    scan_result_t r;
    r.kind  = KIND_REG_WRITE;
    r.addr  = addr;
    r.value = value;
    r.tx    = 8'h00;
    r.last  = 1'b0;
    tick_burst.push_back(r);
  endfunction

  function automatic void add_frame(input logic [7:0] mode, input logic [7:0] d1,
                                    input logic [7:0] d2, input logic [7:0] d3,
                                    input logic [7:0] d4);
    logic [7:0]   frame [8];
    scan_result_t r;
    frame[0] = SYNC_ONE;
    frame[1] = SYNC_TWO;
    frame[2] = mode;
    frame[3] = d1;
    frame[4] = d2;
    frame[5] = d3;
    frame[6] = d4;
    frame[7] = mode ^ d1 ^ d2 ^ d3 ^ d4;
    for (int i = 0; i < 8; i++) begin
      r.kind  = KIND_SERIAL;
      r.addr  = 4'h0;
      r.value = 8'h00;
      r.tx    = frame[i];
      r.last  = 1'b0;
      tick_burst.push_back(r);
    end
  endfunction

  task automatic predict_scan_tick(input logic [31:0] word, input logic [7:0] fan_a,
                                   input logic [7:0] fan_b);
    logic [7:0]   mux_code;
    logic [7:0]   volt_code;
    logic         alt_pair;
    scan_result_t r;
    tick_burst.delete();
    alt_pair  = (chan_sel != CHAN_FIRST);
    volt_code = alt_pair ? MUX_VOLT_B : MUX_VOLT_A;
    if (run_mode != RUN_IDLE) begin
      if (settle_wait != 3'd0) begin
        settle_wait = settle_wait - 3'd1;
      end else begin
        if (slot < 3'd6 && !slot[0]) begin
          cur_reading = word[23:8];
          mux_code    = alt_pair ? MUX_CUR_B : MUX_CUR_A;
        end else if (slot < 3'd6) begin
          volt_reading = word[23:8];
          mux_code     = volt_code;
        end else if (slot == 3'd6) begin
          temp_a   = word[23:16];
          mux_code = MUX_TEMP;
        end else begin
          temp_b   = word[23:16];
          mux_code = volt_code;
        end
        // Oversampling changes precede the mux write on the last voltage and last temp
        if (slot == 3'd5) begin
          add_write(REG_ADDR_OSR, OSR_SLOW);
          settle_wait = WAIT_OSR;
        end else if (slot == 3'd7) begin
          add_write(REG_ADDR_OSR, OSR_FAST);
          settle_wait = WAIT_STD;
        end else begin
          settle_wait = WAIT_STD;
        end
        add_write(REG_ADDR_MUX, mux_code);
        slot = slot + 3'd1;
      end

      meas_ticks = meas_ticks + 16'd1;
      if (run_mode == RUN_STREAM && meas_ticks >= meas_period) begin
        meas_ticks = 16'd0;
        add_frame({6'd0, chan_sel}, cur_reading[15:8], cur_reading[7:0],
                  volt_reading[15:8], volt_reading[7:0]);
      end

      mon_ticks = mon_ticks + 16'd1;
      if (mon_ticks >= mon_period) begin
        mon_ticks = 16'd0;
        add_frame(MON_MODE, temp_a, temp_b, fan_a, fan_b);
      end

      if (tick_burst.size() > 0) begin
        r      = tick_burst.pop_back();
        r.last = 1'b1;
        tick_burst.push_back(r);
      end
      foreach (tick_burst[i]) due_results.push_back(tick_burst[i]);
    end
  endtask

  task automatic check_result();
    scan_result_t got;
    scan_result_t want;
    got.kind  = res_bus.out_kind;
    got.addr  = res_bus.conv_reg_addr;
    got.value = res_bus.conv_reg_value;
    got.tx    = res_bus.tx_byte;
    got.last  = res_bus.last_of_run;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: unexpected result kind=%0d addr=%h value=%h tx=%h last=%0d",
                 $realtime, got.kind, got.addr, got.value, got.tx, got.last);
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display({"%0t: result mismatch: expected kind=%0d addr=%h value=%h tx=%h ",
                    "last=%0d, got kind=%0d addr=%h value=%h tx=%h last=%0d"},
                   $realtime, want.kind, want.addr, want.value, want.tx, want.last,
                   got.kind, got.addr, got.value, got.tx, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      run_mode     = RUN_STATE_RST;
      chan_sel     = CHANNEL_MODE_RST;
      meas_period  = STREAM_PERIOD_RST;
      mon_period   = MONITOR_PERIOD_RST;
      slot         = 3'd0;
      settle_wait  = 3'd0;
      meas_ticks   = 16'd0;
      mon_ticks    = 16'd0;
      cur_reading  = 16'd0;
      volt_reading = 16'd0;
      temp_a       = 8'd0;
      temp_b       = 8'd0;
      due_results.delete();
    end else begin
      // A tick at this edge still sees the old register values
      if (tick_bus.valid && tick_bus.ready)
        predict_scan_tick(tick_bus.adc_sample, tick_bus.fan_one_speed,
                          tick_bus.fan_two_speed);
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUN_STATE:      run_mode    = cfg_data[1:0];
          CFG_CHANNEL_MODE:   chan_sel    = cfg_data[1:0];
          CFG_STREAM_PERIOD:  meas_period = cfg_data[15:0];
          CFG_MONITOR_PERIOD: mon_period  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (res_bus.valid && res_bus.ready)
        check_result();
    end
    pending_count = due_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: clock, reset, tick and register stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import asts_pkg::*;

  localparam logic [1:0] RUN_STANDBY    = 2'd1;
  localparam logic [1:0] RUN_SCAN_ONLY  = 2'd3;
  localparam logic [1:0] CHAN_SECOND    = 2'd2;
  localparam logic [1:0] CHAN_UNUSED_LO = 2'd0;
  localparam logic [1:0] CHAN_UNUSED_HI = 2'd3;

  localparam int RAND_PHASES    = 9;
  localparam int PHASE_TICKS    = 26;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 30;
  localparam int STALL_LIMIT    = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_count;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_taken     = 1'b0;
  int   hold_left      = 0;

  asts_tick_if tick_bus ();
  asts_res_if  res_bus ();

  adc_scan_telemetry_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (tick_bus),
    .out_ch   (res_bus)
  );

  asts_scan_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tick_bus      (tick_bus),
    .res_bus       (res_bus),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_bus.valid && tick_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one tick, idling first at random; returns at the posedge of the transfer
  task automatic send_tick(input logic [31:0] word, input logic [7:0] fan_a,
                           input logic [7:0] fan_b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk);
    end
    tick_bus.valid         <= 1'b1;
    tick_bus.adc_sample    <= word;
    tick_bus.fan_one_speed <= fan_a;
    tick_bus.fan_two_speed <= fan_b;
    do @(posedge clk); while (!tick_bus.ready);
  endtask

  task automatic send_random_ticks(input int count);
    for (int i = 0; i < count; i++)
      send_tick($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait out all results, then let any result-free tick finish
  task automatic drain();
    @(negedge clk);
    tick_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all four registers; upper bits of the narrow ones carry junk to test masking
  task automatic program_regs(input logic [1:0] run_sel, input logic [1:0] chan,
                              input logic [15:0] meas_p, input logic [15:0] mon_p);
    logic [13:0] junk_a;
    logic [13:0] junk_b;
    junk_a    = 14'($urandom);
    junk_b    = 14'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RUN_STATE;
    cfg_data  <= {junk_a, run_sel};
    @(negedge clk);
    cfg_index <= CFG_CHANNEL_MODE;
    cfg_data  <= {junk_b, chan};
    @(negedge clk);
    cfg_index <= CFG_STREAM_PERIOD;
    cfg_data  <= meas_p;
    @(negedge clk);
    cfg_index <= CFG_MONITOR_PERIOD;
    cfg_data  <= mon_p;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_period(input int span);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(1, span));
  endfunction

  function automatic logic [1:0] pick_run();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return RUN_STANDBY;
    if (sel == 3) return RUN_SCAN_ONLY;
    return RUN_STREAM;
  endfunction

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_RUN_STATE;
    cfg_data               = '0;
    tick_bus.valid         = 1'b0;
    tick_bus.adc_sample    = '0;
    tick_bus.fan_one_speed = '0;
    tick_bus.fan_two_speed = '0;
    res_bus.ready          = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Idle after reset: ticks are taken and ignored
    send_tick(32'h00FF_FF00, 8'hFF, 8'hFF);
    send_tick(32'h8000_0000, 8'h00, 8'h00);

    // Both packets on every tick: exercises the longest bursts
    drain();
    program_regs(RUN_STREAM, CHAN_FIRST, 16'd0, 16'd1);
    send_tick(32'h8000_0000, 8'h00, 8'hFF);
    send_tick(32'h7FFF_FFFF, 8'hFF, 8'h00);
    send_tick(32'h0000_0000, 8'h00, 8'h00);
    send_tick(32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_tick(32'h00FF_FF00, 8'h80, 8'h01);
    send_tick(32'hFF00_00FF, 8'h7F, 8'hFE);
    send_tick(32'h0012_3400, 8'h55, 8'hAA);
    send_tick(32'h00AB_CD00, 8'hAA, 8'h55);
    send_tick(32'h5A5A_5A5A, 8'h0F, 8'hF0);

    // Run state three with the second pair: monitor packets only
    drain();
    program_regs(RUN_SCAN_ONLY, CHAN_SECOND, 16'd1, 16'd2);
    send_random_ticks(8);

    // Odd channel codes and the period extremes
    drain();
    program_regs(RUN_STANDBY, CHAN_UNUSED_LO, 16'hFFFF, 16'd0);
    send_random_ticks(3);
    drain();
    program_regs(RUN_STREAM, CHAN_UNUSED_HI, 16'hFFFF, 16'hFFFF);
    send_random_ticks(3);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      program_regs(pick_run(), 2'($urandom_range(0, 3)), pick_period(12), pick_period(30));
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      // Hold off the receiver so the job queue fills and input stalls
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;
      send_random_ticks(PHASE_TICKS);
    end

    drain();
    if (mismatch_count == 0 && pending_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/asts_pkg.sv
hdl/asts_tick_if.sv
hdl/asts_res_if.sv
hdl/asts_front.sv
hdl/asts_queue.sv
hdl/asts_back.sv
hdl/adc_scan_telemetry_sequencer.sv
bench/asts_scan_checker.sv
bench/tb.sv
